// ----- hdl/ibpa_pkg.sv -----
// ----------------------------------------------------------------------------
// ibpa_pkg
// Shared types, codes and helpers of the index buffer primitive assembler.
// ----------------------------------------------------------------------------
package ibpa_pkg;

    localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

    typedef enum logic [2:0] {
        OP_WRITE  = 3'd0,
        OP_APPEND = 3'd1,
        OP_READ   = 3'd2,
        OP_FETCH  = 3'd3,
        OP_TRUNC  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        PK_POINTS    = 3'd0,
        PK_LINES     = 3'd1,
        PK_LINE_STRP = 3'd2,
        PK_TRIS      = 3'd3,
        PK_TRI_STRP  = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_TRUNC = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CFG_FORMAT = 2'd0,
        CFG_KIND   = 2'd1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ES_1 = 2'd0,
        ES_2 = 2'd1,
        ES_4 = 2'd2
    } t_esize;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ISSUE,
        S_LOAD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]  op;
        logic [14:0] position;
        logic [31:0] index_value;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] first_index;
        logic [31:0] second_index;
        logic [31:0] third_index;
        logic [14:0] next_position;
        logic [14:0] element_count;
        logic [14:0] primitive_count;
        logic [1:0]  status;
    } t_out_beat;

    typedef struct packed {
        logic [1:0] reg_index;
        logic [2:0] reg_value;
    } t_cfg_beat;

    typedef struct packed {
        logic   wr;
        logic   rd;
        t_esize size;
    } t_mem_ctl;

    function automatic t_esize fmt_to_size(input logic [2:0] fmt);
        t_esize s;
        case (fmt)
            3'd1:    s = ES_1;
            3'd2:    s = ES_2;
            default: s = ES_4;
        endcase
        return s;
    endfunction

    function automatic logic [31:0] size_mask(input t_esize s);
        logic [31:0] m;
        case (s)
            ES_1:    m = 32'h0000_00ff;
            ES_2:    m = 32'h0000_ffff;
            default: m = 32'hffff_ffff;
        endcase
        return m;
    endfunction

endpackage

// ----- hdl/ibpa_chan_if.sv -----
// ----------------------------------------------------------------------------
// ibpa_chan_if
// Valid/ready channel carrying one payload beat of type T.
// ----------------------------------------------------------------------------
interface ibpa_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/ibpa_ram.sv -----
// ----------------------------------------------------------------------------
// ibpa_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module ibpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hdl/ibpa_store.sv -----
// ----------------------------------------------------------------------------
// ibpa_store
// Element store over four byte lanes: one aligned element written or read
// per access, little-endian, 1, 2 or 4 bytes per element.
// ----------------------------------------------------------------------------
module ibpa_store
    import ibpa_pkg::*;
#(
    parameter int STORE_BYTES = 16384,
    parameter int PW          = 16
) (
    input  logic           i_clk,
    input  t_mem_ctl       i_ctl,
    input  logic [PW-1:0]  i_pos,
    input  logic [31:0]    i_wdata,
    output logic [31:0]    o_rdata
);
    localparam int ROWS = (STORE_BYTES + 3) / 4;
    localparam int RW   = $clog2(ROWS);

    logic [PW+1:0] byte_addr;
    logic [1:0]    lane;
    logic [RW-1:0] row;
    logic [7:0]    q [4];
    logic [1:0]    r_lane;
    t_esize        r_size;

    always_comb begin
        case (i_ctl.size)
            ES_1:    byte_addr = {2'b00, i_pos};
            ES_2:    byte_addr = {1'b0, i_pos, 1'b0};
            default: byte_addr = {i_pos, 2'b00};
        endcase
    end

    assign lane = byte_addr[1:0];
    assign row  = byte_addr[RW+1:2];

    for (genvar k = 0; k < 4; k++) begin : g_lane
        localparam logic [1:0] LANE_ID = 2'(k);
        logic       we;
        logic [7:0] wb;

        always_comb begin
            case (i_ctl.size)
                ES_1: begin
                    we = i_ctl.wr && (lane == LANE_ID);
                    wb = i_wdata[7:0];
                end
                ES_2: begin
                    we = i_ctl.wr && (lane[1] == LANE_ID[1]);
                    wb = i_wdata[8*(k%2) +: 8];
                end
                default: begin
                    we = i_ctl.wr;
                    wb = i_wdata[8*k +: 8];
                end
            endcase
        end

        ibpa_ram #(
            .WIDTH (8),
            .DEPTH (ROWS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (we),
            .i_addr  (row),
            .i_wdata (wb),
            .o_rdata (q[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_lane <= lane;
            r_size <= i_ctl.size;
        end
    end

    always_comb begin
        case (r_size)
            ES_1:    o_rdata = {24'd0, q[r_lane]};
            ES_2:    o_rdata = r_lane[1] ? {16'd0, q[3], q[2]} : {16'd0, q[1], q[0]};
            default: o_rdata = {q[3], q[2], q[1], q[0]};
        endcase
    end
endmodule

// ----- hdl/index_buffer_primitive_assembler.sv -----
// ----------------------------------------------------------------------------
// index_buffer_primitive_assembler
// Vertex index store with write, append, read, primitive fetch and truncate.
// ----------------------------------------------------------------------------
// One beat is taken at a time. Write, append, truncate and unknown ops go
// from one accepted beat to the next through accept, execute and result. A
// read adds an issue state and a load state, a fetch adds both per vertex
// slot of the primitive kind: one slot for points, two for lines and line
// strips, three for triangles and triangle strips. The issue and load states
// come from the single-port element store, which serves one element per
// issue-then-load pair of states. The result sits in an output register, so
// a new beat is taken while a result waits. The store comes up undefined;
// reading an element that was never written returns whatever the memory holds.
module index_buffer_primitive_assembler
    import ibpa_pkg::*;
#(
    parameter int STORE_BYTES = 16384
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ibpa_chan_if.sink   i_in,
    ibpa_chan_if.source o_out,
    ibpa_chan_if.sink   i_cfg
);
    localparam int CW = $clog2(STORE_BYTES + 1);
    localparam int PW = (CW > 16) ? CW : 16;
    localparam int K  = CW + 1;
    localparam logic [CW-1:0] CAP_B1 = CW'(STORE_BYTES);
    localparam logic [CW-1:0] CAP_B2 = CW'(STORE_BYTES / 2);
    localparam logic [CW-1:0] CAP_B4 = CW'(STORE_BYTES / 4);
    localparam logic [K-1:0]  RECIP3 = K'(((64'd1 << K) + 64'd2) / 64'd3);

    t_state        r_state, n_state;
    t_op           r_op, n_op;
    logic [14:0]   r_pos, n_pos;
    logic [31:0]   r_val, n_val;
    logic [1:0]    r_slot, n_slot;
    logic [1:0]    r_nslots, n_nslots;
    logic [31:0]   r_idx [3];
    logic [31:0]   n_idx [3];
    logic [14:0]   r_next, n_next;
    t_status       r_status, n_status;
    logic          r_hit, n_hit;
    logic [CW-1:0] r_count, n_count;
    t_esize        r_size, n_size;
    t_kind         r_kind, n_kind;
    t_out_beat     r_out, n_out;
    logic          r_out_valid, n_out_valid;

    logic [PW-1:0]   pos_ext, cnt_ext, cap_ext, wpos, slot_pos, mem_pos;
    logic [CW-1:0]   cap_new;
    logic            slot_hit, in_acc, cfg_acc;
    logic [31:0]     mask, rdata;
    logic [CW+K-1:0] prod3;
    logic [PW-1:0]   prim_cnt;
    logic [1:0]      step;
    t_mem_ctl        mem_ctl;

    function automatic logic [CW-1:0] cap_of(input t_esize s);
        logic [CW-1:0] c;
        case (s)
            ES_1:    c = CAP_B1;
            ES_2:    c = CAP_B2;
            default: c = CAP_B4;
        endcase
        return c;
    endfunction

    assign in_acc   = i_in.valid && i_in.ready;
    assign cfg_acc  = i_cfg.valid && i_cfg.ready;
    assign pos_ext  = PW'(r_pos);
    assign cnt_ext  = PW'(r_count);
    assign cap_ext  = PW'(cap_of(r_size));
    assign wpos     = (r_op == OP_APPEND) ? cnt_ext : pos_ext;
    assign slot_pos = pos_ext + PW'(r_slot);
    assign slot_hit = (slot_pos < cnt_ext) && (slot_pos < cap_ext);
    assign mask     = size_mask(r_size);
    assign mem_pos  = (r_state == S_ISSUE) ? slot_pos : wpos;
    assign cap_new  = cap_of(fmt_to_size(i_cfg.data.reg_value));

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // count / 3 by reciprocal, exact over the whole count range
    assign prod3 = (CW+K)'(r_count) * (CW+K)'(RECIP3);

    always_comb begin
        case (r_kind)
            PK_POINTS:    prim_cnt = cnt_ext;
            PK_LINES:     prim_cnt = cnt_ext >> 1;
            PK_LINE_STRP: prim_cnt = (cnt_ext >= PW'(1)) ? cnt_ext - PW'(1) : '0;
            PK_TRIS:      prim_cnt = PW'(prod3[CW+K-1:K]);
            PK_TRI_STRP:  prim_cnt = (cnt_ext >= PW'(2)) ? cnt_ext - PW'(2) : '0;
            default:      prim_cnt = '0;
        endcase
    end

    ibpa_store #(
        .STORE_BYTES (STORE_BYTES),
        .PW          (PW)
    ) u_store (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_pos   (mem_pos),
        .i_wdata (r_val & mask),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_pos       = r_pos;
        n_val       = r_val;
        n_slot      = r_slot;
        n_nslots    = r_nslots;
        n_idx       = r_idx;
        n_next      = r_next;
        n_status    = r_status;
        n_hit       = r_hit;
        n_count     = r_count;
        n_size      = r_size;
        n_kind      = r_kind;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        step        = 2'd1;
        mem_ctl     = '{wr: 1'b0, rd: 1'b0, size: r_size};

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_op    = t_op'(i_in.data.op);
                    n_pos   = i_in.data.position;
                    n_val   = i_in.data.index_value;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_idx[0] = ALL_ONES;
                n_idx[1] = ALL_ONES;
                n_idx[2] = ALL_ONES;
                n_next   = '0;
                n_status = ST_OK;
                n_slot   = '0;
                n_nslots = '0;
                n_state  = S_DONE;
                case (r_op)
                    OP_WRITE, OP_APPEND: begin
                        if (wpos >= cap_ext) begin
                            n_status = ST_RANGE;
                        end else begin
                            mem_ctl.wr = 1'b1;
                            if (wpos >= cnt_ext) begin
                                n_count = CW'(wpos + PW'(1));
                            end
                            if ((r_val & ~mask) != '0) begin
                                n_status = ST_TRUNC;
                            end
                        end
                    end
                    OP_READ: begin
                        if (pos_ext >= cap_ext) begin
                            n_status = ST_RANGE;
                        end
                        n_nslots = 2'd1;
                        n_state  = S_ISSUE;
                    end
                    OP_FETCH: begin
                        if (pos_ext >= cap_ext) begin
                            n_status = ST_RANGE;
                        end
                        case (r_kind)
                            PK_POINTS: begin
                                n_nslots = 2'd1;
                                step     = 2'd1;
                            end
                            PK_LINES: begin
                                n_nslots = 2'd2;
                                step     = 2'd2;
                            end
                            PK_LINE_STRP: begin
                                n_nslots = 2'd2;
                                step     = 2'd1;
                            end
                            PK_TRIS: begin
                                n_nslots = 2'd3;
                                step     = 2'd3;
                            end
                            PK_TRI_STRP: begin
                                n_nslots = 2'd3;
                                step     = 2'd1;
                            end
                            default: begin
                                n_nslots = 2'd0;
                                step     = 2'd1;
                            end
                        endcase
                        n_next = 15'(16'(r_pos) + 16'(step));
                        if (n_nslots != 2'd0) begin
                            n_state = S_ISSUE;
                        end
                    end
                    OP_TRUNC: begin
                        if (pos_ext > cap_ext) begin
                            n_status = ST_RANGE;
                        end
                        if (pos_ext < cnt_ext) begin
                            n_count = CW'(pos_ext);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_ISSUE: begin
                mem_ctl.rd = slot_hit;
                n_hit      = slot_hit;
                n_state    = S_LOAD;
            end
            S_LOAD: begin
                if (r_hit) begin
                    n_idx[r_slot] = rdata;
                end
                n_slot = r_slot + 2'd1;
                if ((r_slot + 2'd1) == r_nslots) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_ISSUE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out.first_index     = r_idx[0];
                    n_out.second_index    = r_idx[1];
                    n_out.third_index     = r_idx[2];
                    n_out.next_position   = r_next;
                    n_out.element_count   = cnt_ext[14:0];
                    n_out.primitive_count = prim_cnt[14:0];
                    n_out.status          = r_status;
                    n_out_valid           = 1'b1;
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (cfg_acc) begin
            case (t_cfg_reg'(i_cfg.data.reg_index))
                CFG_FORMAT: begin
                    n_size = fmt_to_size(i_cfg.data.reg_value);
                    if (r_count > cap_new) begin
                        n_count = cap_new;
                    end
                end
                CFG_KIND: begin
                    n_kind = t_kind'(i_cfg.data.reg_value);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_size      <= ES_2;
            r_kind      <= PK_TRIS;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_size      <= n_size;
            r_kind      <= n_kind;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_slot   <= n_slot;
        r_nslots <= n_nslots;
        r_idx    <= n_idx;
        r_next   <= n_next;
        r_status <= n_status;
        r_hit    <= n_hit;
        r_out    <= n_out;
    end

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_ext <= cap_ext)
        else $error("element count above capacity");

    a_rd_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_ctl.rd |-> (slot_pos < cnt_ext) && (r_state == S_ISSUE))
        else $error("store read outside valid elements");

    a_wr_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_ctl.wr |-> (wpos < cap_ext) && (r_state == S_EXEC))
        else $error("store write beyond capacity");

    a_out_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result beat raised outside completion");
endmodule
